// ===== rtl/core/vad_pkg.sv =====
// ----------------------------------------------------------------------------
// Vibration activity detector package
// Shared types, constants and codes for the detector core.
// ----------------------------------------------------------------------------
package vad_pkg;

  localparam logic [7:0] SAMPLES_PER_SECOND_MAX = 8'd200;
  localparam logic [4:0] SECONDS_PER_WINDOW_MAX = 5'd20;
  localparam int         MAG_SHIFT              = 14;
  localparam logic [7:0] COUNT_SAT              = 8'd255;
  localparam int         ITER_STEPS             = 32;

  localparam logic [1:0] REQ_SAMPLE = 2'd0;
  localparam logic [1:0] REQ_SECOND = 2'd1;
  localparam logic [1:0] REQ_WINDOW = 2'd2;

  localparam logic [1:0] MODE_ON      = 2'd0;
  localparam logic [1:0] MODE_OFF     = 2'd1;
  localparam logic [1:0] MODE_TRUEOFF = 2'd2;

  localparam logic [1:0] OP_MUL  = 2'd0;
  localparam logic [1:0] OP_SQRT = 2'd1;
  localparam logic [1:0] OP_DIV  = 2'd2;

  localparam logic [2:0] REG_OFFSET          = 3'd0;
  localparam logic [2:0] REG_QUIET_THRESHOLD = 3'd1;
  localparam logic [2:0] REG_GAIN_XY         = 3'd2;
  localparam logic [2:0] REG_GAIN_Z          = 3'd3;
  localparam logic [2:0] REG_OFF_WINDOW_LIMIT = 3'd4;
  localparam logic [2:0] REG_TRUE_OFF_LIMIT  = 3'd5;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } vad_in_t;

  typedef struct packed {
    logic [23:0] window_mean;
    logic        mean_valid;
    logic        quiet;
    logic [1:0]  machine_mode;
    logic        notify;
  } vad_out_t;

  typedef struct packed {
    logic [23:0] offset;
    logic [23:0] quiet_threshold;
    logic [15:0] gain_xy;
    logic [15:0] gain_z;
    logic [7:0]  off_window_limit;
    logic [7:0]  true_off_limit;
  } vad_cfg_t;

  typedef struct packed {
    logic        start;
    logic [1:0]  op;
    logic [63:0] a;
    logic [31:0] b;
  } vad_iter_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] result;
  } vad_iter_rsp_t;

endpackage

// ===== rtl/core/vad_iter_unit.sv =====
// ----------------------------------------------------------------------------
// Shared iterative arithmetic unit
// Registered multiply, and a shared compare/subtract stage that runs either
// a restoring square root (two bits per step) or a restoring division (one
// bit per step) over 32 steps.
// ----------------------------------------------------------------------------
module vad_iter_unit
  import vad_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  vad_iter_req_t req,
  output vad_iter_rsp_t rsp
);

  logic        busy;
  logic        done;
  logic [4:0]  cnt;
  logic [1:0]  op_r;
  logic [63:0] n;
  logic [35:0] rem;
  logic [31:0] q;
  logic [31:0] divisor;
  logic [63:0] prod;

  logic [35:0] cand;
  logic [35:0] trial;
  logic [35:0] diff;
  logic        ge;

  always_comb begin
    if (op_r == OP_SQRT) begin
      cand  = {rem[33:0], n[63:62]};
      trial = {2'b00, q, 2'b01};
    end else begin
      cand  = {rem[34:0], n[63]};
      trial = {4'b0000, divisor};
    end
    ge   = cand >= trial;
    diff = cand - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      op_r <= OP_MUL;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        op_r <= req.op;
        if (req.op == OP_MUL) begin
          prod <= 64'(req.a[31:0]) * 64'(req.b);
          done <= 1'b1;
        end else begin
          n       <= req.a;
          rem     <= '0;
          q       <= '0;
          divisor <= req.b;
          cnt     <= '0;
          busy    <= 1'b1;
        end
      end else if (busy) begin
        rem <= ge ? diff : cand;
        q   <= {q[30:0], ge};
        if (op_r == OP_SQRT) begin
          n <= {n[61:0], 2'b00};
        end else begin
          n <= {n[62:0], 1'b0};
        end
        cnt <= cnt + 5'd1;
        if (cnt == 5'(ITER_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done   = done;
  assign rsp.result = (op_r == OP_MUL) ? prod : {32'b0, q};

endmodule

// ===== rtl/core/vad_mode_fsm.sv =====
// ----------------------------------------------------------------------------
// Activity mode machine
// Judges a window against offset and threshold and keeps the
// ON / OFF / TRUEOFF mode with its off and true-off counters.
// ----------------------------------------------------------------------------
module vad_mode_fsm
  import vad_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        upd,
  input  logic [23:0] mean,
  input  logic        mean_valid,
  input  vad_cfg_t    cfg,
  output vad_out_t    res
);

  logic [1:0]  mode;
  logic        cur_active;
  logic [7:0]  off_windows;
  logic [7:0]  true_off_windows;

  logic [23:0] dev;
  logic        quiet;
  logic        act;
  logic [1:0]  mode_next;
  logic [7:0]  off_windows_next;
  logic [7:0]  true_off_windows_next;
  logic        notify;

  always_comb begin
    dev   = (mean >= cfg.offset) ? (mean - cfg.offset) : (cfg.offset - mean);
    quiet = mean_valid && (dev < cfg.quiet_threshold);
    act   = mean_valid && !quiet;
    notify = 1'b0;
    if (cur_active || act) begin
      mode_next             = MODE_ON;
      off_windows_next      = '0;
      true_off_windows_next = '0;
    end else begin
      mode_next             = (mode == MODE_TRUEOFF) ? MODE_TRUEOFF : MODE_OFF;
      off_windows_next      = off_windows;
      true_off_windows_next = true_off_windows;
    end
    if (mode_next == MODE_OFF && off_windows_next != COUNT_SAT) begin
      off_windows_next = off_windows_next + 8'd1;
    end
    if (off_windows_next >= cfg.off_window_limit) begin
      if (true_off_windows_next != COUNT_SAT) begin
        true_off_windows_next = true_off_windows_next + 8'd1;
        notify = (true_off_windows_next == cfg.true_off_limit);
      end
      if (true_off_windows_next >= cfg.true_off_limit) begin
        mode_next = MODE_TRUEOFF;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= MODE_TRUEOFF;
      cur_active       <= 1'b0;
      off_windows      <= '0;
      true_off_windows <= '0;
    end else if (upd) begin
      mode             <= mode_next;
      cur_active       <= act;
      off_windows      <= off_windows_next;
      true_off_windows <= true_off_windows_next;
    end
  end

  assign res.window_mean  = mean;
  assign res.mean_valid   = mean_valid;
  assign res.quiet        = quiet;
  assign res.machine_mode = mode_next;
  assign res.notify       = notify;

endmodule

// ===== rtl/core/vibration_activity_detector_core.sv =====
// ----------------------------------------------------------------------------
// Vibration activity detector core
// Accumulates gain-weighted acceleration magnitudes per second and per
// window, and reports window mean, quiet flag and machine mode.
//
//   Channel  Signals                        Direction  Beat
//   in       in_valid, in_ready, in_data    to core    sample or tick
//   out      out_valid, out_ready, out_data from core  window result
//   cfg      cfg_we, cfg_index, cfg_data    to core    register write
//
// A sample makes six passes through the shared multiplier
// and 32 square root steps in the iterative unit.
// A one-second tick with samples under the second cap and a window tick with
// a valid window each run the 32 division steps of the same unit.
// Reset is synchronous and needs no clearing pass. A stalled output holds one
// result while the next beats are taken; only a second window result waits for
// the output register.
// ----------------------------------------------------------------------------
module vibration_activity_detector_core
  import vad_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  vad_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output vad_out_t    out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_MUL_G     = 4'd1;
  localparam logic [3:0] ST_MUL_SQ    = 4'd2;
  localparam logic [3:0] ST_ACC       = 4'd3;
  localparam logic [3:0] ST_SQRT      = 4'd4;
  localparam logic [3:0] ST_SQRT_WAIT = 4'd5;
  localparam logic [3:0] ST_SEC_DIV   = 4'd6;
  localparam logic [3:0] ST_SEC_WAIT  = 4'd7;
  localparam logic [3:0] ST_WIN_DIV   = 4'd8;
  localparam logic [3:0] ST_WIN_WAIT  = 4'd9;
  localparam logic [3:0] ST_FINISH    = 4'd10;

  vad_cfg_t      cfg;
  logic [3:0]    state;
  vad_in_t       in_reg;
  logic [1:0]    axis;
  logic [63:0]   acc;
  logic [31:0]   sample_sum;
  logic [7:0]    sample_count;
  logic [28:0]   second_sum;
  logic [4:0]    second_count;
  logic          window_invalid;
  logic [23:0]   mean;
  logic          mean_valid;

  vad_iter_req_t iter_req;
  vad_iter_rsp_t iter_rsp;
  vad_out_t      res;
  logic          mode_upd;
  logic          out_free;
  logic          in_fire;

  logic [16:0]   axis_ext;
  logic [16:0]   axis_abs;
  logic [15:0]   axis_gain;

  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign mode_upd = (state == ST_FINISH) && out_free;

  always_comb begin
    case (axis)
      2'd0:    axis_ext = {in_reg.accel_x[15], in_reg.accel_x};
      2'd1:    axis_ext = {in_reg.accel_y[15], in_reg.accel_y};
      default: axis_ext = {in_reg.accel_z[15], in_reg.accel_z};
    endcase
    axis_abs  = axis_ext[16] ? (17'd0 - axis_ext) : axis_ext;
    axis_gain = (axis == 2'd2) ? cfg.gain_z : cfg.gain_xy;
  end

  always_comb begin
    iter_req.start = 1'b0;
    iter_req.op    = OP_MUL;
    iter_req.a     = '0;
    iter_req.b     = '0;
    case (state)
      ST_MUL_G: begin
        iter_req.start = 1'b1;
        iter_req.a     = {47'b0, axis_abs};
        iter_req.b     = {16'b0, axis_gain};
      end
      ST_MUL_SQ: begin
        iter_req.start = 1'b1;
        iter_req.a     = {32'b0, iter_rsp.result[31:0]};
        iter_req.b     = iter_rsp.result[31:0];
      end
      ST_SQRT: begin
        iter_req.start = 1'b1;
        iter_req.op    = OP_SQRT;
        iter_req.a     = acc;
      end
      ST_SEC_DIV: begin
        iter_req.start = 1'b1;
        iter_req.op    = OP_DIV;
        iter_req.a     = {sample_sum, 32'b0};
        iter_req.b     = {24'b0, sample_count};
      end
      ST_WIN_DIV: begin
        iter_req.start = 1'b1;
        iter_req.op    = OP_DIV;
        iter_req.a     = {3'b0, second_sum, 32'b0};
        iter_req.b     = {27'b0, second_count};
      end
      default: begin
        iter_req.start = 1'b0;
      end
    endcase
  end

  vad_iter_unit u_iter (
    .clk (clk),
    .rst (rst),
    .req (iter_req),
    .rsp (iter_rsp)
  );

  vad_mode_fsm u_mode (
    .clk        (clk),
    .rst        (rst),
    .upd        (mode_upd),
    .mean       (mean),
    .mean_valid (mean_valid),
    .cfg        (cfg),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.offset           <= 24'd0;
      cfg.quiet_threshold  <= 24'd0;
      cfg.gain_xy          <= 16'd25600;
      cfg.gain_z           <= 16'd26;
      cfg.off_window_limit <= 8'd24;
      cfg.true_off_limit   <= 8'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OFFSET:           cfg.offset           <= cfg_data;
        REG_QUIET_THRESHOLD:  cfg.quiet_threshold  <= cfg_data;
        REG_GAIN_XY:          cfg.gain_xy          <= cfg_data[15:0];
        REG_GAIN_Z:           cfg.gain_z           <= cfg_data[15:0];
        REG_OFF_WINDOW_LIMIT: cfg.off_window_limit <= cfg_data[7:0];
        REG_TRUE_OFF_LIMIT:   cfg.true_off_limit   <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      sample_sum     <= '0;
      sample_count   <= '0;
      second_sum     <= '0;
      second_count   <= '0;
      window_invalid <= 1'b0;
      out_valid      <= 1'b0;
      axis           <= '0;
    end else begin
      if (out_valid && out_ready && !mode_upd) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            in_reg <= in_data;
            case (in_data.req_type)
              REQ_SAMPLE: begin
                if (sample_count < SAMPLES_PER_SECOND_MAX) begin
                  acc   <= '0;
                  axis  <= '0;
                  state <= ST_MUL_G;
                end
              end
              REQ_SECOND: begin
                if (second_count < SECONDS_PER_WINDOW_MAX && sample_count != 8'd0) begin
                  state <= ST_SEC_DIV;
                end else begin
                  if (second_count < SECONDS_PER_WINDOW_MAX) begin
                    window_invalid <= 1'b1;
                    second_count   <= second_count + 5'd1;
                  end
                  sample_sum   <= '0;
                  sample_count <= '0;
                end
              end
              REQ_WINDOW: begin
                if (second_count != 5'd0 && !window_invalid) begin
                  state <= ST_WIN_DIV;
                end else begin
                  mean       <= '0;
                  mean_valid <= 1'b0;
                  state      <= ST_FINISH;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_MUL_G: begin
          state <= ST_MUL_SQ;
        end
        ST_MUL_SQ: begin
          state <= ST_ACC;
        end
        ST_ACC: begin
          acc <= acc + iter_rsp.result;
          if (axis == 2'd2) begin
            state <= ST_SQRT;
          end else begin
            axis  <= axis + 2'd1;
            state <= ST_MUL_G;
          end
        end
        ST_SQRT: begin
          state <= ST_SQRT_WAIT;
        end
        ST_SQRT_WAIT: begin
          if (iter_rsp.done) begin
            sample_sum   <= sample_sum + {14'b0, iter_rsp.result[31:MAG_SHIFT]};
            sample_count <= sample_count + 8'd1;
            state        <= ST_IDLE;
          end
        end
        ST_SEC_DIV: begin
          state <= ST_SEC_WAIT;
        end
        ST_SEC_WAIT: begin
          if (iter_rsp.done) begin
            second_sum   <= second_sum + iter_rsp.result[28:0];
            second_count <= second_count + 5'd1;
            sample_sum   <= '0;
            sample_count <= '0;
            state        <= ST_IDLE;
          end
        end
        ST_WIN_DIV: begin
          state <= ST_WIN_WAIT;
        end
        ST_WIN_WAIT: begin
          if (iter_rsp.done) begin
            mean       <= iter_rsp.result[23:0];
            mean_valid <= 1'b1;
            state      <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_data       <= res;
            out_valid      <= 1'b1;
            second_sum     <= '0;
            second_count   <= '0;
            window_invalid <= 1'b0;
            state          <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_sample_cap: assert property (@(posedge clk) disable iff (rst)
    sample_count <= SAMPLES_PER_SECOND_MAX)
    else $error("sample count passed its cap");

  a_second_cap: assert property (@(posedge clk) disable iff (rst)
    second_count <= SECONDS_PER_WINDOW_MAX)
    else $error("second count passed its cap");

  a_done_when_waiting: assert property (@(posedge clk) disable iff (rst)
    iter_rsp.done |-> (state == ST_MUL_SQ || state == ST_ACC || state == ST_SQRT_WAIT ||
                       state == ST_SEC_WAIT || state == ST_WIN_WAIT))
    else $error("arithmetic unit finished outside a waiting state");

  a_finish_loads: assert property (@(posedge clk) disable iff (rst)
    mode_upd |=> out_valid && state == ST_IDLE)
    else $error("window result was not loaded");

  a_quiet_needs_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.quiet && !out_data.mean_valid))
    else $error("quiet flag on an invalid window");
`endif

endmodule
